FILE: hdl/tpsp_pkg.sv
// Shared constants, types and color table of the triangle pixel shader.
`timescale 1ns / 1ps
package tpsp_pkg;

	localparam int FRAC_BITS_DEF = 24;

	localparam int COORD_W  = 14;
	localparam int DEPTH_IN_W = 24;
	localparam int UV_IN_W  = 36;
	localparam int PIX_W    = 12;
	localparam int BPP_W    = 4;
	localparam int BPL_W    = 16;
	localparam int OFFS_W   = 27;
	localparam int COLOR_W  = 8;
	localparam int TEX_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Edge weights of covered pixels stay below 2^29.
	localparam int WGT_W = 30;
	// Low part of u and v in the split multiply.
	localparam int UV_SPLIT = 18;
	// Registered stages of the divider.
	localparam int DIV_LAT = 18;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;
	localparam logic [1:0] SLOT_NONE = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP_LEFT   = 3'd0,
		REG_CLIP_RIGHT  = 3'd1,
		REG_CLIP_TOP    = 3'd2,
		REG_CLIP_BOTTOM = 3'd3,
		REG_BPP         = 3'd4,
		REG_BPL         = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} color_t;

	// Color code is bit 3 of u plus bit 3 of v.
	function automatic color_t pick_color(input logic [1:0] code);
		color_t c;
		unique case (code)
			2'd0: c = '{red: 8'd100, green: 8'd100, blue: 8'd255};
			2'd1: c = '{red: 8'd100, green: 8'd255, blue: 8'd100};
			default: c = '{red: 8'd255, green: 8'd100, blue: 8'd100};
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/tpsp_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface tpsp_item_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   kind;
	logic [1:0]                             vertex_slot;
	logic signed [tpsp_pkg::COORD_W-1:0]    vert_x;
	logic signed [tpsp_pkg::COORD_W-1:0]    vert_y;
	logic [tpsp_pkg::DEPTH_IN_W-1:0]        vert_depth;
	logic signed [tpsp_pkg::UV_IN_W-1:0]    vert_u;
	logic signed [tpsp_pkg::UV_IN_W-1:0]    vert_v;
	logic [tpsp_pkg::PIX_W-1:0]             pixel_x;
	logic [tpsp_pkg::PIX_W-1:0]             pixel_y;

	modport source (output valid, kind, vertex_slot, vert_x, vert_y, vert_depth, vert_u,
		vert_v, pixel_x, pixel_y, input ready);
	modport sink (input valid, kind, vertex_slot, vert_x, vert_y, vert_depth, vert_u,
		vert_v, pixel_x, pixel_y, output ready);
endinterface

interface tpsp_result_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 drawn;
	logic [tpsp_pkg::OFFS_W-1:0]          pixel_offset;
	logic [tpsp_pkg::COLOR_W-1:0]         red;
	logic [tpsp_pkg::COLOR_W-1:0]         green;
	logic [tpsp_pkg::COLOR_W-1:0]         blue;
	logic signed [tpsp_pkg::TEX_W-1:0]    texel_u;
	logic signed [tpsp_pkg::TEX_W-1:0]    texel_v;

	modport source (output valid, drawn, pixel_offset, red, green, blue, texel_u, texel_v,
		input ready);
	modport sink (input valid, drawn, pixel_offset, red, green, blue, texel_u, texel_v,
		output ready);
endinterface

FILE: hdl/tpsp_div.sv
// Pipelined signed-by-positive divider with truncation and 16-bit saturation.
`timescale 1ns / 1ps
module tpsp_div #(
	parameter int N_W = tpsp_pkg::FRAC_BITS_DEF + 12 + tpsp_pkg::WGT_W + 2,
	parameter int D_W = tpsp_pkg::FRAC_BITS_DEF + tpsp_pkg::WGT_W + 2
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [N_W-1:0]            num,
	input  logic [D_W-1:0]                   den,
	output logic signed [tpsp_pkg::TEX_W-1:0] quo
);
	localparam int QB = tpsp_pkg::TEX_W;
	localparam int RW = (N_W > D_W + QB) ? N_W : D_W + QB;

	logic          neg_a;
	logic [N_W-1:0] mag_a;
	logic [D_W-1:0] den_a;

	logic          neg_s [QB+1];
	logic          sat_s [QB+1];
	logic [RW-1:0] rem_s [QB+1];
	logic [D_W-1:0] den_s [QB+1];
	logic [QB-1:0] q_s   [QB+1];

	// take the magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			neg_a <= num[N_W-1];
			mag_a <= num[N_W-1] ? N_W'(-num) : N_W'(num);
			den_a <= den;
		end
	end

	// check for overflow of the 16-bit quotient
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= neg_a;
			sat_s[0] <= RW'(mag_a) >= (RW'(den_a) << QB);
			rem_s[0] <= RW'(mag_a);
			den_s[0] <= den_a;
			q_s[0]   <= '0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar t = 0; t < QB; t++) begin : g_bit
		localparam int K = QB - 1 - t;
		logic [RW-1:0] trial;
		logic          fits;
		assign trial = RW'(den_s[t]) << K;
		assign fits  = rem_s[t] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[t+1] <= neg_s[t];
				sat_s[t+1] <= sat_s[t];
				den_s[t+1] <= den_s[t];
				rem_s[t+1] <= fits ? rem_s[t] - trial : rem_s[t];
				q_s[t+1]   <= q_s[t] | (fits ? (QB'(1) << K) : '0);
			end
		end
	end

	logic [QB-1:0] q_fin;
	assign q_fin = q_s[QB];

	always_comb begin
		priority if (sat_s[QB]) begin
			quo = neg_s[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
		end else if (neg_s[QB]) begin
			quo = (q_fin > {1'b1, {(QB-1){1'b0}}}) ? {1'b1, {(QB-1){1'b0}}} : -q_fin;
		end else begin
			quo = q_fin[QB-1] ? {1'b0, {(QB-1){1'b1}}} : q_fin;
		end
	end

endmodule

FILE: hdl/triangle_pixel_shader_perspective_unit.sv
// Top level of the perspective-correct triangle pixel shader.
`timescale 1ns / 1ps
// Vertex items load one of three triangle corners; pixel items ask whether a screen
// pixel is covered and return one result each (vertex items return none). The block is
// a fixed pipeline of 26 register stages from the input transfer to the result register:
// seven stages of edge, area and interpolation arithmetic, 18 stages of the divider that
// recovers u and v one quotient bit per stage, and the result register. One item enters
// per clock, up to one result leaves per clock; the whole pipeline holds while one waits
// untaken, so input ready follows result ready. Corner position takes effect for the next
// item; corner depth and texture values are written when the vertex item reaches the
// interpolation stage, so every pixel sees exactly the corners loaded before it.
// Configuration writes take effect at once and belong to idle periods.
module triangle_pixel_shader_perspective_unit #(
	parameter int FRAC_BITS = tpsp_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tpsp_item_if.sink                         item,
	tpsp_result_if.source                     result,
	input  logic                              wr_en,
	input  logic [tpsp_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [tpsp_pkg::CFG_DATA_W-1:0]   wr_data
);
	localparam int DEPTH_W = FRAC_BITS;
	localparam int UV_W    = FRAC_BITS + 12;
	localparam int WW      = tpsp_pkg::WGT_W;
	localparam int SPL     = tpsp_pkg::UV_SPLIT;
	localparam int UH_W    = UV_W - SPL;
	localparam int D_W     = DEPTH_W + WW + 2;
	localparam int N_W     = UV_W + WW + 2;
	localparam int CW      = tpsp_pkg::COORD_W;
	localparam int DW      = CW + 1;        // corner differences
	localparam int PW      = 2 * DW;        // edge products
	localparam int EW      = PW + 1;        // edge values
	localparam int PXW     = tpsp_pkg::PIX_W;
	localparam int OW      = tpsp_pkg::OFFS_W;
	localparam int LAT     = tpsp_pkg::DIV_LAT;

	// pipeline advances unless a finished result waits
	logic en, in_fire;
	assign en         = !result.valid || result.ready;
	assign item.ready = en;
	assign in_fire    = item.valid && en;

	// configuration registers
	logic [PXW-1:0] clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;
	logic [tpsp_pkg::BPP_W-1:0] bpp_q;
	logic [tpsp_pkg::BPL_W-1:0] bpl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_right_q  <= '1;
			clip_top_q    <= '0;
			clip_bottom_q <= '1;
			bpp_q         <= tpsp_pkg::BPP_W'(3);
			bpl_q         <= tpsp_pkg::BPL_W'(3072);
		end else if (wr_en) begin
			unique case (wr_index)
				tpsp_pkg::REG_CLIP_LEFT:   clip_left_q   <= wr_data[PXW-1:0];
				tpsp_pkg::REG_CLIP_RIGHT:  clip_right_q  <= wr_data[PXW-1:0];
				tpsp_pkg::REG_CLIP_TOP:    clip_top_q    <= wr_data[PXW-1:0];
				tpsp_pkg::REG_CLIP_BOTTOM: clip_bottom_q <= wr_data[PXW-1:0];
				tpsp_pkg::REG_BPP:         bpp_q         <= wr_data[tpsp_pkg::BPP_W-1:0];
				tpsp_pkg::REG_BPL:         bpl_q         <= wr_data;
				default: ;
			endcase
		end
	end

	// corner store: position written on transfer, depth and texture at stage 4
	logic signed [CW-1:0]     cx_q [3];
	logic signed [CW-1:0]     cy_q [3];
	logic [DEPTH_W-1:0]       cz_q [3];
	logic signed [UV_W-1:0]   cu_q [3];
	logic signed [UV_W-1:0]   cv_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				cx_q[i] <= '0;
				cy_q[i] <= '0;
			end
		end else if (in_fire && item.kind == tpsp_pkg::KIND_VERTEX
				&& item.vertex_slot != tpsp_pkg::SLOT_NONE) begin
			cx_q[item.vertex_slot] <= item.vert_x;
			cy_q[item.vertex_slot] <= item.vert_y;
		end
	end

	// stage 1: corner differences, clip test, offset products
	logic                   v_s1, kind_s1;
	logic [1:0]             slot_s1;
	logic [DEPTH_W-1:0]     z_s1;
	logic signed [UV_W-1:0] u_s1, vv_s1;
	logic signed [DW-1:0]   dx_s1 [3], dy_s1 [3], ex_s1 [3], ey_s1 [3];
	logic                   clip_s1;
	logic [15:0]            offx_s1;
	logic [27:0]            offy_s1;

	logic signed [DW-1:0] px_c, py_c;
	assign px_c = $signed({3'b000, item.pixel_x});
	assign py_c = $signed({3'b000, item.pixel_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= item.kind;
			slot_s1 <= item.vertex_slot;
			z_s1    <= item.vert_depth[DEPTH_W-1:0];
			u_s1    <= item.vert_u[UV_W-1:0];
			vv_s1   <= item.vert_v[UV_W-1:0];
			for (int i = 0; i < 3; i++) begin
				dx_s1[i] <= px_c - DW'(cx_q[i]);
				dy_s1[i] <= py_c - DW'(cy_q[i]);
				ex_s1[i] <= DW'(cx_q[(i+1)%3]) - DW'(cx_q[i]);
				ey_s1[i] <= DW'(cy_q[(i+1)%3]) - DW'(cy_q[i]);
			end
			clip_s1 <= item.pixel_x >= clip_left_q && item.pixel_x <= clip_right_q
				&& item.pixel_y >= clip_top_q && item.pixel_y <= clip_bottom_q;
			offx_s1 <= item.pixel_x * bpp_q;
			offy_s1 <= item.pixel_y * bpl_q;
		end
	end

	// stage 2: edge products and byte offset
	logic                   v_s2, kind_s2, clip_s2;
	logic [1:0]             slot_s2;
	logic [DEPTH_W-1:0]     z_s2;
	logic signed [UV_W-1:0] u_s2, vv_s2;
	logic signed [PW-1:0]   pa_s2 [3], pb_s2 [3];
	logic [OW-1:0]          off_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			slot_s2 <= slot_s1;
			z_s2    <= z_s1;
			u_s2    <= u_s1;
			vv_s2   <= vv_s1;
			clip_s2 <= clip_s1;
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= dx_s1[i] * ey_s1[i];
				pb_s2[i] <= dy_s1[i] * ex_s1[i];
			end
			off_s2 <= OW'(29'(offx_s1) + 29'(offy_s1));
		end
	end

	// stage 3: edge functions
	logic                   v_s3, kind_s3, clip_s3;
	logic [1:0]             slot_s3;
	logic [DEPTH_W-1:0]     z_s3;
	logic signed [UV_W-1:0] u_s3, vv_s3;
	logic signed [EW-1:0]   e_s3 [3];
	logic [OW-1:0]          off_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_s2;
			slot_s3 <= slot_s2;
			z_s3    <= z_s2;
			u_s3    <= u_s2;
			vv_s3   <= vv_s2;
			clip_s3 <= clip_s2;
			off_s3  <= off_s2;
			for (int i = 0; i < 3; i++) e_s3[i] <= EW'(pa_s2[i]) - EW'(pb_s2[i]);
		end
	end

	// stage 4: area and coverage; weights for interpolation
	logic                   v_s4, kind_s4, cov_s4;
	logic [1:0]             slot_s4;
	logic [DEPTH_W-1:0]     z_s4;
	logic signed [UV_W-1:0] u_s4, vv_s4;
	logic [WW-1:0]          w_s4 [3];
	logic [OW-1:0]          off_s4;

	logic signed [EW+1:0] area_c;
	assign area_c = (EW+2)'(e_s3[0]) + (EW+2)'(e_s3[1]) + (EW+2)'(e_s3[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4 <= kind_s3;
			slot_s4 <= slot_s3;
			z_s4    <= z_s3;
			u_s4    <= u_s3;
			vv_s4   <= vv_s3;
			off_s4  <= off_s3;
			cov_s4  <= clip_s3 && area_c > 0 && !e_s3[0][EW-1] && !e_s3[1][EW-1]
				&& !e_s3[2][EW-1];
			for (int i = 0; i < 3; i++) w_s4[i] <= e_s3[i][WW-1:0];
		end
	end

	// depth and texture corners: written as the vertex item passes stage 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				cz_q[i] <= '0;
				cu_q[i] <= '0;
				cv_q[i] <= '0;
			end
		end else if (en && v_s4 && kind_s4 == tpsp_pkg::KIND_VERTEX
				&& slot_s4 != tpsp_pkg::SLOT_NONE) begin
			cz_q[slot_s4] <= z_s4;
			cu_q[slot_s4] <= u_s4;
			cv_q[slot_s4] <= vv_s4;
		end
	end

	// stage 5: partial products; corner i pairs with the weight of the next edge
	logic                          v_s5, cov_s5;
	logic [OW-1:0]                 off_s5;
	logic [D_W-3:0]                dz_s5 [3];
	logic [SPL+WW-1:0]             ul_s5 [3], vl_s5 [3];
	logic signed [UH_W+WW:0]       uh_s5 [3], vh_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4 && kind_s4 == tpsp_pkg::KIND_PIXEL;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cov_s5 <= cov_s4;
			off_s5 <= off_s4;
			for (int i = 0; i < 3; i++) begin
				dz_s5[i] <= cz_q[i] * w_s4[(i+1)%3];
				ul_s5[i] <= cu_q[i][SPL-1:0] * w_s4[(i+1)%3];
				vl_s5[i] <= cv_q[i][SPL-1:0] * w_s4[(i+1)%3];
				uh_s5[i] <= $signed(cu_q[i][UV_W-1:SPL]) * $signed({1'b0, w_s4[(i+1)%3]});
				vh_s5[i] <= $signed(cv_q[i][UV_W-1:SPL]) * $signed({1'b0, w_s4[(i+1)%3]});
			end
		end
	end

	// stage 6: depth sum, recombine the split products
	logic                   v_s6, cov_s6;
	logic [OW-1:0]          off_s6;
	logic [D_W-1:0]         d_s6;
	logic signed [N_W-1:0]  nu_s6 [3], nv_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cov_s6 <= cov_s5;
			off_s6 <= off_s5;
			d_s6   <= D_W'(dz_s5[0]) + D_W'(dz_s5[1]) + D_W'(dz_s5[2]);
			for (int i = 0; i < 3; i++) begin
				nu_s6[i] <= (N_W'(uh_s5[i]) <<< SPL) + N_W'(ul_s5[i]);
				nv_s6[i] <= (N_W'(vh_s5[i]) <<< SPL) + N_W'(vl_s5[i]);
			end
		end
	end

	// stage 7: numerator sums, final coverage
	logic                   v_s7, drawn_s7;
	logic [OW-1:0]          off_s7;
	logic [D_W-1:0]         d_s7;
	logic signed [N_W-1:0]  nu_s7, nv_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drawn_s7 <= cov_s6 && d_s6 != '0;
			off_s7   <= off_s6;
			d_s7     <= d_s6;
			nu_s7    <= nu_s6[0] + nu_s6[1] + nu_s6[2];
			nv_s7    <= nv_s6[0] + nv_s6[1] + nv_s6[2];
		end
	end

	// divider stages, one per coordinate
	logic signed [tpsp_pkg::TEX_W-1:0] tu_c, tv_c;

	tpsp_div #(.N_W(N_W), .D_W(D_W)) u_div_u (
		.clk (clk), .en (en), .num (nu_s7), .den (d_s7), .quo (tu_c)
	);

	tpsp_div #(.N_W(N_W), .D_W(D_W)) u_div_v (
		.clk (clk), .en (en), .num (nv_s7), .den (d_s7), .quo (tv_c)
	);

	// side band travels alongside the divider
	logic          v_sd     [LAT];
	logic          drawn_sd [LAT];
	logic [OW-1:0] off_sd   [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) v_sd[i] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s7;
			for (int i = 1; i < LAT; i++) v_sd[i] <= v_sd[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drawn_sd[0] <= drawn_s7;
			off_sd[0]   <= off_s7;
			for (int i = 1; i < LAT; i++) begin
				drawn_sd[i] <= drawn_sd[i-1];
				off_sd[i]   <= off_sd[i-1];
			end
		end
	end

	// result register: pick the color, zero the color and texel fields of undrawn pixels
	tpsp_pkg::color_t col_c;
	assign col_c = tpsp_pkg::pick_color(2'(tu_c[3]) + 2'(tv_c[3]));

	logic                              res_v_q, drawn_q;
	logic [OW-1:0]                     off_q;
	tpsp_pkg::color_t                  col_q;
	logic signed [tpsp_pkg::TEX_W-1:0] tu_q, tv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (en) res_v_q <= v_sd[LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drawn_q <= drawn_sd[LAT-1];
			off_q   <= off_sd[LAT-1];
			col_q   <= drawn_sd[LAT-1] ? col_c : '0;
			tu_q    <= drawn_sd[LAT-1] ? tu_c : '0;
			tv_q    <= drawn_sd[LAT-1] ? tv_c : '0;
		end
	end

	assign result.valid        = res_v_q;
	assign result.drawn        = drawn_q;
	assign result.pixel_offset = off_q;
	assign result.red          = col_q.red;
	assign result.green        = col_q.green;
	assign result.blue         = col_q.blue;
	assign result.texel_u      = tu_q;
	assign result.texel_v      = tv_q;

endmodule
